// ===== sv/point_mass_euler_step_assert.svh =====
// Assertion macros shared by the checker.
`ifndef POINT_MASS_EULER_STEP_ASSERT_SVH
`define POINT_MASS_EULER_STEP_ASSERT_SVH
`define PMES_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PMES_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== sv/pmes_pkg.sv =====
package pmes_pkg;
    localparam int unsigned FracBits = 16;
    localparam int unsigned CfgW = 31;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_MASS = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DRAG = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAXS = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RAD = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ALIVE = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_EPS = 3'd5;
    localparam logic [1:0] KIND_FORCE = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic [30:0] step_size;
        logic signed [31:0] other_x;
        logic signed [31:0] other_y;
        logic [30:0] other_radius;
        logic other_alive;
        logic same_body;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic collided;
    } t_out;

    typedef struct packed {
        logic start;
        logic is_div;
        logic [63:0] num;
        logic [63:0] den;
    } t_unit_req;

    typedef struct packed {
        logic done;
        logic [63:0] res;
    } t_unit_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// ===== sv/pmes_if.sv =====
interface pmes_in_if;
    import pmes_pkg::*;
    logic valid;
    logic ready;
    t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pmes_out_if;
    import pmes_pkg::*;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pmes_divsqrt.sv =====
module pmes_divsqrt (
    input  logic i_clk,
    input  logic i_rst_n,
    input  pmes_pkg::t_unit_req i_req,
    output pmes_pkg::t_unit_rsp o_rsp
);
    import pmes_pkg::*;
    // Radix-2 restoring divider, or bit-pair square root, one bit per cycle.
    logic [63:0] r_num, r_den, r_quo, r_rem, r_bit;
    logic [6:0] r_cnt;
    logic r_busy, r_div, r_done;
    logic [64:0] w_trial;
    logic [63:0] w_rem_sh, w_sq;

    always_comb begin
        w_rem_sh = {r_rem[62:0], r_num[63]};
        w_trial = {1'b0, w_rem_sh} - {1'b0, r_den};
        w_sq = r_quo + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div <= i_req.is_div;
                r_num <= i_req.num;
                r_den <= i_req.den;
                r_quo <= '0;
                r_rem <= '0;
                r_bit <= 64'h4000_0000_0000_0000;
                r_cnt <= i_req.is_div ? 7'd64 : 7'd32;
            end else if (r_busy) begin
                if (r_div) begin
                    r_num <= {r_num[62:0], 1'b0};
                    if (!w_trial[64]) begin
                        r_rem <= w_trial[63:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                end else begin
                    if (r_num >= w_sq) begin
                        r_num <= r_num - w_sq;
                        r_quo <= (r_quo >> 1) + r_bit;
                    end else begin
                        r_quo <= r_quo >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res = r_quo;
endmodule

// ===== sv/point_mass_euler_step.sv =====
// Force, query, dead-body and unused-kind items go from S_DISP to S_OUT; a query that tests a
// live other body passes S_Q1 and S_Q2 first. A step item runs its divides and square roots
// in turn on one shared divide and square-root unit, one quotient or root bit per cycle.
// One item is in flight at a time; the next input transfer can come in the cycle after the
// result is registered, and a result waiting on the output side does not block the input.
// Synchronous active-low reset clears the body state, loads default config and idles the FSM.
module point_mass_euler_step (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [pmes_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [pmes_pkg::CfgW-1:0] i_cfg_data,
    pmes_in_if.sink in_ch,
    pmes_out_if.source out_ch
);
    import pmes_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0, S_DISP = 5'd1, S_AXD = 5'd2, S_AYD = 5'd3,
        S_VX = 5'd4, S_VY = 5'd5, S_FMAG = 5'd6, S_SP1 = 5'd7, S_LOSS = 5'd8,
        S_RX = 5'd9, S_RXD = 5'd10, S_RY = 5'd11, S_RYD = 5'd12, S_SP2 = 5'd13,
        S_PX = 5'd14, S_PY = 5'd15, S_Q1 = 5'd16, S_Q2 = 5'd17, S_OUT = 5'd18,
        S_SQ = 5'd19, S_MX = 5'd20, S_MY = 5'd21;

    logic [30:0] r_mass, r_drag, r_maxs, r_rad, r_eps;
    logic r_alive;
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_fx, r_fy, r_ax;
    t_in r_in;
    logic [4:0] r_st, r_ret;
    logic r_phase;
    logic [63:0] r_speed, r_ns, r_a, r_b, r_tmp;
    logic r_hit, r_ov;
    t_unit_req r_req;
    t_unit_rsp w_rsp;
    logic r_oval;
    t_out r_out;
    logic signed [32:0] r_ma;
    logic [31:0] r_mb;
    logic [64:0] w_prod;
    logic [63:0] w_mag_shift;
    logic signed [65:0] w_addq;

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    pmes_divsqrt u_unit (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    always_comb begin
        w_prod = 65'({1'b0, 32'(r_ma[32] ? -r_ma : r_ma)}) * 65'(r_mb);
        w_mag_shift = 64'(w_prod >> FracBits);
        w_addq = r_ma[32] ? -66'($signed({2'b0, w_mag_shift})) : 66'($signed({2'b0, w_mag_shift}));
    end

    assign in_ch.ready = (r_st == S_IDLE);
    assign out_ch.valid = r_oval;
    assign out_ch.data = r_out;

    always_ff @(posedge i_clk) begin
        logic [63:0] q;
        logic [63:0] dx, dy, rr;
        if (!i_rst_n) begin
            r_mass <= 31'(1 << FracBits);
            r_drag <= '0;
            r_maxs <= 31'(1000 << FracBits);
            r_rad <= '0;
            r_alive <= 1'b1;
            r_eps <= 31'd1;
            r_px <= '0; r_py <= '0; r_vx <= '0; r_vy <= '0; r_fx <= '0; r_fy <= '0;
            r_st <= S_IDLE;
            r_oval <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MASS: r_mass <= i_cfg_data;
                    CFG_DRAG: r_drag <= i_cfg_data;
                    CFG_MAXS: r_maxs <= i_cfg_data;
                    CFG_RAD: r_rad <= i_cfg_data;
                    CFG_ALIVE: r_alive <= i_cfg_data[0];
                    CFG_EPS: r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_st == S_OUT && (!r_oval || out_ch.ready)) begin
                r_oval <= 1'b1;
            end else if (out_ch.ready) begin
                r_oval <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: if (in_ch.valid && in_ch.ready) begin
                    r_in <= in_ch.data;
                    r_hit <= 1'b0;
                    r_st <= S_DISP;
                end
                S_DISP: begin
                    r_st <= S_OUT;
                    if (r_alive && r_in.kind == KIND_FORCE) begin
                        r_fx <= sat32(66'(r_fx) + 66'(r_in.force_x));
                        r_fy <= sat32(66'(r_fy) + 66'(r_in.force_y));
                    end else if (r_alive && r_in.kind == KIND_STEP) begin
                        r_req <= '{1'b1, 1'b1, 64'(mag(r_fx)) << FracBits,
                                   (r_mass == '0) ? 64'd1 : 64'(r_mass)};
                        r_st <= S_AXD;
                    end else if (r_alive && r_in.kind == KIND_QUERY && r_in.other_alive
                                 && !r_in.same_body) begin
                        r_st <= S_Q1;
                    end
                end
                S_AXD: if (w_rsp.done) begin
                    q = (w_rsp.res > 64'h8000_0000) ? 64'h8000_0000 : w_rsp.res;
                    r_ax <= sat32(r_fx[31] ? -66'(q) : 66'(q));
                    r_req <= '{1'b1, 1'b1, 64'(mag(r_fy)) << FracBits,
                               (r_mass == '0) ? 64'd1 : 64'(r_mass)};
                    r_st <= S_AYD;
                end
                S_AYD: if (w_rsp.done) begin
                    q = (w_rsp.res > 64'h8000_0000) ? 64'h8000_0000 : w_rsp.res;
                    r_ma <= 33'(r_ax);
                    r_mb <= 32'(r_in.step_size);
                    r_tmp <= 64'(sat32(r_fy[31] ? -66'(q) : 66'(q)));
                    r_st <= S_VX;
                end
                S_VX: begin
                    r_vx <= sat32(66'(r_vx) + w_addq);
                    r_ma <= 33'($signed(r_tmp[31:0]));
                    r_st <= S_VY;
                end
                S_VY: begin
                    r_vy <= sat32(66'(r_vy) + w_addq);
                    r_req <= '{1'b1, 1'b0, 64'(mag(r_fx)) * 64'(mag(r_fx))
                               + 64'(mag(r_fy)) * 64'(mag(r_fy)), 64'd0};
                    r_st <= S_FMAG;
                end
                S_FMAG: if (w_rsp.done) begin
                    if (w_rsp.res < 64'(r_eps)) begin
                        r_req <= '{1'b1, 1'b0, 64'(mag(r_vx)) * 64'(mag(r_vx))
                                   + 64'(mag(r_vy)) * 64'(mag(r_vy)), 64'd0};
                        r_st <= S_SP1;
                    end else begin
                        r_st <= S_SQ;
                    end
                end
                S_SP1: if (w_rsp.done) begin
                    r_speed <= w_rsp.res;
                    if (64'(r_drag) > w_rsp.res) begin
                        r_vx <= '0; r_vy <= '0;
                        r_st <= S_SQ;
                    end else if (w_rsp.res == 64'd0) begin
                        r_st <= S_SQ;
                    end else begin
                        r_ma <= 33'(r_drag);
                        r_mb <= 32'(r_in.step_size);
                        r_st <= S_LOSS;
                    end
                end
                S_LOSS: begin
                    r_ns <= (w_mag_shift >= r_speed) ? 64'd0 : r_speed - w_mag_shift;
                    r_ret <= S_SQ;
                    r_phase <= 1'b0;
                    r_st <= S_RX;
                end
                S_RX: begin
                    r_req <= '{1'b1, 1'b1,
                               64'(mag(r_phase ? r_vy : r_vx)) * 64'(r_ns[31:0]), r_speed};
                    r_st <= S_RXD;
                end
                S_RXD: if (w_rsp.done) begin
                    if (!r_phase) begin
                        r_vx <= sat32(r_vx[31] ? -66'(w_rsp.res) : 66'(w_rsp.res));
                        r_phase <= 1'b1;
                        r_st <= S_RX;
                    end else begin
                        r_vy <= sat32(r_vy[31] ? -66'(w_rsp.res) : 66'(w_rsp.res));
                        r_st <= r_ret;
                    end
                end
                S_SQ: begin
                    r_req <= '{1'b1, 1'b0, 64'(mag(r_vx)) * 64'(mag(r_vx))
                               + 64'(mag(r_vy)) * 64'(mag(r_vy)), 64'd0};
                    r_st <= S_SP2;
                end
                S_SP2: if (w_rsp.done) begin
                    if (w_rsp.res > 64'(r_maxs)) begin
                        r_speed <= w_rsp.res;
                        r_ns <= 64'(r_maxs);
                        r_ret <= S_MX;
                        r_phase <= 1'b0;
                        r_st <= S_RX;
                    end else begin
                        r_st <= S_MX;
                    end
                end
                S_MX: begin
                    r_ma <= 33'(r_vx);
                    r_mb <= 32'(r_in.step_size);
                    r_st <= S_PX;
                end
                S_PX: begin
                    r_px <= sat32(66'(r_px) + w_addq);
                    r_ma <= 33'(r_vy);
                    r_st <= S_MY;
                end
                S_MY: r_st <= S_PY;
                S_PY: begin
                    r_py <= sat32(66'(r_py) + w_addq);
                    r_fx <= '0; r_fy <= '0;
                    r_st <= S_OUT;
                end
                S_Q1: begin
                    dx = 64'(mag33(33'(r_px) - 33'(r_in.other_x)));
                    dy = 64'(mag33(33'(r_py) - 33'(r_in.other_y)));
                    rr = 64'(r_rad) + 64'(r_in.other_radius);
                    r_ov <= (dx < rr) && (dy < rr);
                    r_a <= dx * dx;
                    r_b <= dy * dy;
                    r_tmp <= rr * rr;
                    r_st <= S_Q2;
                end
                S_Q2: begin
                    r_hit <= r_ov && (r_a < r_tmp) && (r_b < r_tmp - r_a);
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_oval || out_ch.ready) begin
                    r_out <= '{r_px, r_py, r_vx, r_vy, r_hit};
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/pmes_checker.sv =====
`include "point_mass_euler_step_assert.svh"
module pmes_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_collided
);
    `PMES_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, in_valid && in_ready, !in_ready)
    `PMES_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `PMES_ASSERT_NXT(a_out_data_holds, i_clk, i_rst_n, out_valid && !out_ready, $stable(out_collided))
endmodule

bind point_mass_euler_step pmes_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_collided(out_ch.data.collided)
);
